@@ design/amc_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the accumulator machine core
// no dependencies; imported by the core and its checker

package amc_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PC_W       = 7;
  localparam int unsigned MEM_WORDS  = 100;
  localparam int unsigned MEM_AW     = $clog2(MEM_WORDS);
  localparam int unsigned CNT_W      = $clog2(DATA_W);
  localparam int unsigned OP_W       = 6;
  localparam int unsigned INS_W      = 13;
  localparam int unsigned STATUS_W   = 3;

  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned S_TUSER_W  = 1;
  localparam int unsigned M_TDATA_W  = 72;
  localparam int unsigned M_TUSER_W  = 5;

  localparam logic signed [DATA_W-1:0] LOAD_END = -32'sd99999;

  // instruction word range that can hold a known opcode
  localparam logic [DATA_W-1:0] INS_LOW  = 32'd1000;
  localparam logic [DATA_W-1:0] INS_HIGH = 32'd4400;

  // reciprocal of 100 scaled by 2^19, exact for words below INS_HIGH
  localparam int unsigned       RECIP_SHIFT = 19;
  localparam logic [INS_W-1:0]  RECIP_100   = 13'd5243;
  localparam logic [INS_W-1:0]  DEC_BASE    = 13'd100;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 6'd10,
    OP_WRITE = 6'd11,
    OP_LOAD  = 6'd20,
    OP_STORE = 6'd21,
    OP_ADD   = 6'd30,
    OP_SUB   = 6'd31,
    OP_DIV   = 6'd32,
    OP_MUL   = 6'd33,
    OP_JMP   = 6'd40,
    OP_JNEG  = 6'd41,
    OP_JZ    = 6'd42,
    OP_HALT  = 6'd43
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_HALT    = 3'd1,
    ST_FULL    = 3'd2,
    ST_BADOP   = 3'd3,
    ST_DIVZ    = 3'd4,
    ST_PCRANGE = 3'd5,
    ST_LOADED  = 3'd6
  } status_e;

endpackage

@@ design/accumulator_machine_core_unit.sv @@
`timescale 1ns / 1ps
// accumulator machine core: sequencer, 100-word memory and one shared 32-bit adder
// depends on amc_pkg

// Takes one transaction at a time and returns exactly one result transaction
// for it. A load passes through the load step, a stopped step through the check
// step, and a plain instruction through check, fetch, decode, operand read and
// execute. Multiply and divide run 32 shift-and-add or restore-and-subtract steps
// through the single 32-bit adder. The memory read port is registered. Unwritten
// words read as zero through per-word valid bits cleared at reset; there is no
// clearing pass. The next input is accepted while the previous result still
// waits on the output register.

module accumulator_machine_core_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [amc_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // word
  input  logic [amc_pkg::S_TUSER_W-1:0]     s_axis_tuser,   // command
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [amc_pkg::M_TDATA_W-1:0]     m_axis_tdata,   // print_value, program_counter,
                                                            // accumulator_value, zero pad
  output logic [amc_pkg::M_TUSER_W-1:0]     m_axis_tuser    // status, print_valid, read_taken
);
  import amc_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_LOAD   = 12'b0000_0000_0010,
    S_CHECK  = 12'b0000_0000_0100,
    S_FETCH  = 12'b0000_0000_1000,
    S_DECODE = 12'b0000_0001_0000,
    S_EXEC   = 12'b0000_0010_0000,
    S_DIVA   = 12'b0000_0100_0000,
    S_DIVB   = 12'b0000_1000_0000,
    S_DIV    = 12'b0001_0000_0000,
    S_MUL    = 12'b0010_0000_0000,
    S_DIVF   = 12'b0100_0000_0000,
    S_FINISH = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [DATA_W-1:0]   word_q, word_d;
  logic [DATA_W-1:0]   acc_q, acc_d;
  logic [PC_W-1:0]     pc_q, pc_d;
  logic [PC_W-1:0]     ldp_q, ldp_d;
  logic                stopped_q, stopped_d;
  status_e             cause_q, cause_d;

  op_e                 op_q, op_d;
  logic [INS_W-1:0]    ins_q, ins_d;
  logic                bad_q, bad_d;
  logic [PC_W-1:0]     addr_q, addr_d;

  logic [DATA_W-1:0]   rem_q, rem_d;
  logic [DATA_W-1:0]   quo_q, quo_d;
  logic [DATA_W-1:0]   opb_q, opb_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                neg_q, neg_d;

  status_e             res_status_q, res_status_d;
  logic                res_pvalid_q, res_pvalid_d;
  logic [DATA_W-1:0]   res_pvalue_q, res_pvalue_d;
  logic                res_rtaken_q, res_rtaken_d;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q;
  logic                out_pvalid_q;
  logic [DATA_W-1:0]   out_pvalue_q;
  logic                out_rtaken_q;
  logic [PC_W-1:0]     out_pc_q;
  logic [DATA_W-1:0]   out_acc_q;
  logic                out_load;

  // word memory with per-word valid bits
  logic [DATA_W-1:0]   mem_q [MEM_WORDS];
  logic [MEM_WORDS-1:0] valid_q;
  logic                mem_we;
  logic [MEM_AW-1:0]   mem_widx;
  logic [DATA_W-1:0]   mem_wdata;
  logic                rd_en;
  logic [PC_W-1:0]     rd_addr;
  logic [DATA_W-1:0]   rdata_q;
  logic                rhit_q;
  logic [DATA_W-1:0]   mem_val;

  // shared adder
  logic [DATA_W-1:0]   alu_a, alu_b;
  logic                alu_sub;
  logic [DATA_W:0]     alu_sum;

  logic [PC_W-1:0]     pc_inc;
  logic [INS_W-1:0]    ins_low;
  logic [2*INS_W-1:0]  recip_prod;
  logic [INS_W-1:0]    op_scaled;
  logic [INS_W-1:0]    addr_full;
  logic [DATA_W-1:0]   div_shift;
  logic                s_fire;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_acc_q, out_pc_q, out_pvalue_q};
  assign m_axis_tuser  = {out_rtaken_q, out_pvalid_q, out_status_q};

  assign alu_sum    = {1'b0, alu_a} + {1'b0, alu_b ^ {DATA_W{alu_sub}}} + (DATA_W + 1)'(alu_sub);
  assign pc_inc     = pc_q + PC_W'(1);
  assign mem_val    = rhit_q ? rdata_q : '0;
  assign ins_low    = mem_val[INS_W-1:0];
  assign recip_prod = (2*INS_W)'(ins_low) * (2*INS_W)'(RECIP_100);
  assign op_scaled  = INS_W'(op_q) * DEC_BASE;
  assign addr_full  = ins_q - op_scaled;
  assign div_shift  = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
  assign out_load   = (state_q == S_FINISH) && (!out_valid_q || m_axis_tready);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_EXEC: begin
        alu_a   = acc_q;
        alu_b   = mem_val;
        alu_sub = (op_q == OP_SUB);
      end
      S_DIVA, S_DIVF: begin
        alu_b   = quo_q;
        alu_sub = 1'b1;
      end
      S_DIVB: begin
        alu_b   = opb_q;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = div_shift;
        alu_b   = opb_q;
        alu_sub = 1'b1;
      end
      S_MUL: begin
        alu_a = rem_q;
        alu_b = opb_q;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    word_d       = word_q;
    acc_d        = acc_q;
    pc_d         = pc_q;
    ldp_d        = ldp_q;
    stopped_d    = stopped_q;
    cause_d      = cause_q;
    op_d         = op_q;
    ins_d        = ins_q;
    bad_d        = bad_q;
    addr_d       = addr_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    opb_d        = opb_q;
    cnt_d        = cnt_q;
    neg_d        = neg_q;
    res_status_d = res_status_q;
    res_pvalid_d = res_pvalid_q;
    res_pvalue_d = res_pvalue_q;
    res_rtaken_d = res_rtaken_q;
    out_valid_d  = out_valid_q;
    mem_we       = 1'b0;
    mem_widx     = '0;
    mem_wdata    = word_q;
    rd_en        = 1'b0;
    rd_addr      = pc_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          word_d       = s_axis_tdata;
          res_status_d = ST_OK;
          res_pvalid_d = 1'b0;
          res_pvalue_d = '0;
          res_rtaken_d = 1'b0;
          state_d      = s_axis_tuser[0] ? S_CHECK : S_LOAD;
        end
      end
      S_LOAD: begin
        if (word_q == LOAD_END) begin
          pc_d         = '0;
          acc_d        = '0;
          ldp_d        = '0;
          stopped_d    = 1'b0;
          cause_d      = ST_OK;
          res_status_d = ST_LOADED;
        end else if (ldp_q >= PC_W'(MEM_WORDS)) begin
          res_status_d = ST_FULL;
        end else begin
          mem_we   = 1'b1;
          mem_widx = ldp_q[MEM_AW-1:0];
          ldp_d    = ldp_q + PC_W'(1);
          if (ldp_q + PC_W'(1) >= PC_W'(MEM_WORDS)) begin
            res_status_d = ST_FULL;
          end
        end
        state_d = S_FINISH;
      end
      S_CHECK: begin
        if (stopped_q) begin
          res_status_d = cause_q;
          state_d      = S_FINISH;
        end else if (pc_q >= PC_W'(MEM_WORDS)) begin
          stopped_d    = 1'b1;
          cause_d      = ST_PCRANGE;
          res_status_d = ST_PCRANGE;
          state_d      = S_FINISH;
        end else begin
          rd_en   = 1'b1;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        bad_d   = mem_val[DATA_W-1] || (mem_val < INS_LOW) || (mem_val >= INS_HIGH);
        ins_d   = ins_low;
        op_d    = op_e'(recip_prod[RECIP_SHIFT +: OP_W]);
        state_d = S_DECODE;
      end
      S_DECODE: begin
        addr_d  = addr_full[PC_W-1:0];
        rd_addr = addr_full[PC_W-1:0];
        unique case (op_q) inside
          OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_DIV, OP_MUL,
          OP_JMP, OP_JNEG, OP_JZ, OP_HALT: begin
            if (bad_q) begin
              stopped_d    = 1'b1;
              cause_d      = ST_BADOP;
              res_status_d = ST_BADOP;
              state_d      = S_FINISH;
            end else begin
              rd_en   = 1'b1;
              state_d = S_EXEC;
            end
          end
          default: begin
            stopped_d    = 1'b1;
            cause_d      = ST_BADOP;
            res_status_d = ST_BADOP;
            state_d      = S_FINISH;
          end
        endcase
      end
      S_EXEC: begin
        pc_d     = pc_inc;
        state_d  = S_FINISH;
        mem_widx = addr_q[MEM_AW-1:0];
        case (op_q)
          OP_READ: begin
            mem_we       = (addr_q < PC_W'(MEM_WORDS));
            res_rtaken_d = 1'b1;
          end
          OP_WRITE: begin
            res_pvalid_d = 1'b1;
            res_pvalue_d = mem_val;
          end
          OP_LOAD: begin
            acc_d = mem_val;
          end
          OP_STORE: begin
            mem_we    = (addr_q < PC_W'(MEM_WORDS));
            mem_wdata = acc_q;
          end
          OP_ADD, OP_SUB: begin
            acc_d = alu_sum[DATA_W-1:0];
          end
          OP_DIV: begin
            if (mem_val == '0) begin
              pc_d         = pc_q;
              stopped_d    = 1'b1;
              cause_d      = ST_DIVZ;
              res_status_d = ST_DIVZ;
            end else begin
              pc_d    = pc_q;
              quo_d   = acc_q;
              opb_d   = mem_val;
              rem_d   = '0;
              neg_d   = acc_q[DATA_W-1] ^ mem_val[DATA_W-1];
              state_d = S_DIVA;
            end
          end
          OP_MUL: begin
            pc_d    = pc_q;
            quo_d   = acc_q;
            opb_d   = mem_val;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = S_MUL;
          end
          OP_JMP: begin
            pc_d = addr_q;
          end
          OP_JNEG: begin
            if (acc_q[DATA_W-1]) begin
              pc_d = addr_q;
            end
          end
          OP_JZ: begin
            if (acc_q == '0) begin
              pc_d = addr_q;
            end
          end
          OP_HALT: begin
            pc_d         = pc_q;
            stopped_d    = 1'b1;
            cause_d      = ST_HALT;
            res_status_d = ST_HALT;
          end
          default: begin
            pc_d         = pc_q;
            stopped_d    = 1'b1;
            cause_d      = ST_BADOP;
            res_status_d = ST_BADOP;
          end
        endcase
      end
      S_DIVA: begin
        if (quo_q[DATA_W-1]) begin
          quo_d = alu_sum[DATA_W-1:0];
        end
        state_d = S_DIVB;
      end
      S_DIVB: begin
        if (opb_q[DATA_W-1]) begin
          opb_d = alu_sum[DATA_W-1:0];
        end
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (alu_sum[DATA_W]) begin
          rem_d = alu_sum[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_d = div_shift;
          quo_d = {quo_q[DATA_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == '1) begin
          state_d = S_DIVF;
        end
      end
      S_DIVF: begin
        acc_d   = neg_q ? alu_sum[DATA_W-1:0] : quo_q;
        pc_d    = pc_inc;
        state_d = S_FINISH;
      end
      S_MUL: begin
        if (quo_q[0]) begin
          rem_d = alu_sum[DATA_W-1:0];
        end
        opb_d = {opb_q[DATA_W-2:0], 1'b0};
        quo_d = {1'b0, quo_q[DATA_W-1:1]};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == '1) begin
          acc_d   = quo_q[0] ? alu_sum[DATA_W-1:0] : rem_q;
          pc_d    = pc_inc;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      pc_q        <= '0;
      ldp_q       <= '0;
      stopped_q   <= 1'b0;
      cause_q     <= ST_OK;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      rhit_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      pc_q        <= pc_d;
      ldp_q       <= ldp_d;
      stopped_q   <= stopped_d;
      cause_q     <= cause_d;
      out_valid_q <= out_valid_d;
      if (mem_we) begin
        valid_q[mem_widx] <= 1'b1;
      end
      if (rd_en) begin
        rhit_q <= (rd_addr < PC_W'(MEM_WORDS)) && valid_q[rd_addr[MEM_AW-1:0]];
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    op_q         <= op_d;
    ins_q        <= ins_d;
    bad_q        <= bad_d;
    addr_q       <= addr_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    opb_q        <= opb_d;
    cnt_q        <= cnt_d;
    neg_q        <= neg_d;
    res_status_q <= res_status_d;
    res_pvalid_q <= res_pvalid_d;
    res_pvalue_q <= res_pvalue_d;
    res_rtaken_q <= res_rtaken_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_pvalid_q <= res_pvalid_q;
      out_pvalue_q <= res_pvalue_q;
      out_rtaken_q <= res_rtaken_q;
      out_pc_q     <= pc_q;
      out_acc_q    <= acc_q;
    end
  end

  // word memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_widx] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr[MEM_AW-1:0]];
    end
  end

endmodule

@@ design/amc_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the accumulator machine core and the bind that attaches them
// depends on amc_pkg and accumulator_machine_core_unit

module amc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [amc_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // word
  input logic [amc_pkg::S_TUSER_W-1:0]     s_axis_tuser,   // command
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [amc_pkg::M_TDATA_W-1:0]     m_axis_tdata,   // print_value, program_counter,
                                                           // accumulator_value, zero pad
  input logic [amc_pkg::M_TUSER_W-1:0]     m_axis_tuser    // status, print_valid, read_taken
);
  import amc_pkg::*;

  // one transaction in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("core ready again right after accepting a transaction");

  // a printed value only comes with a clean step that took no read
  a_print_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3] |->
      (m_axis_tuser[2:0] == ST_OK) && !m_axis_tuser[4])
    else $error("print flagged with bad status or read");

  a_print_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[3] |-> (m_axis_tdata[31:0] == '0))
    else $error("print value not zero without print flag");

  // end of loading restarts the machine
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[2:0] == ST_LOADED) |->
      (m_axis_tdata[38:32] == '0) && (m_axis_tdata[70:39] == '0))
    else $error("load done with non-zero counter or accumulator");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind accumulator_machine_core_unit amc_checker u_amc_checker (.*);
